>>> rtl/bgmf_pkg.sv
// bgmf_pkg: shared types, sizes and helper functions for the blank gap midpoint finder
// used by blank_gap_midpoint_finder and the testbench; depends on nothing else
package bgmf_pkg;

   localparam int MAX_WIDTH   = 1024;
   localparam int MAX_HEIGHT  = 1024;
   localparam int XW          = $clog2(MAX_WIDTH);
   localparam int YW          = $clog2(MAX_HEIGHT);

   localparam int SIZE_W      = 11;
   localparam int TILE_W      = 7;
   localparam int POS_W       = 11;
   localparam int COUNT_W     = 10;
   localparam int CSR_IDX_W   = 2;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // result queue
   localparam int RESULTS_MAX = 3;
   localparam int FIFO_DEPTH  = 8;
   localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
   localparam int FIFO_CW     = $clog2(FIFO_DEPTH + 1);
   localparam int NUM_W       = $clog2(RESULTS_MAX + 1);

   typedef enum logic [1:0] {
      KIND_COLUMN_GAP = 2'd0,
      KIND_ROW_GAP    = 2'd1,
      KIND_SUMMARY    = 2'd2
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_FRAME_WIDTH  = 2'd0,
      REG_FRAME_HEIGHT = 2'd1,
      REG_TILES_ACROSS = 2'd2,
      REG_TILES_DOWN   = 2'd3
   } reg_index_type;

   typedef struct packed {
      kind_type           kind;
      logic [POS_W-1:0]   position;
      logic               layout_ok;
      logic [COUNT_W-1:0] column_gaps;
      logic [COUNT_W-1:0] row_gaps;
      logic               last;
   } result_type;

   // zero acts as one, oversize saturates
   function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                    input logic [SIZE_W-1:0] lim);
      logic [SIZE_W-1:0] r;
      if (v == '0) begin
         r = SIZE_W'(1);
      end else if (v > lim) begin
         r = lim;
      end else begin
         r = v;
      end
      return r;
   endfunction

   function automatic logic [COUNT_W-1:0] bump(input logic [COUNT_W-1:0] c);
      return (c == COUNT_MAX) ? COUNT_MAX : c + COUNT_W'(1);
   endfunction

endpackage

>>> rtl/blank_gap_midpoint_finder.sv
// blank_gap_midpoint_finder: top level, pixel stream in, gap midpoints and frame summary out
// depends on bgmf_pkg
//
// usage
//  - req_* carries one binarized pixel per beat in raster order (ink in req_tdata bit 0)
//  - rsp_* carries results: column gap midpoints (emitted while the last row streams),
//    row gap midpoints (at each row end) and one summary beat after the frame's last pixel
//  - rsp_tlast marks the last result beat caused by one pixel
//  - csr_* writes frame size and expected tile counts; write only while the block is idle
// timing
//  - one pixel per cycle while the result queue has room; the accept stage registers
//    the pixel and reads the column memory, then the pixel stage pushes its results
//    into an 8-deep result queue whose head drives rsp_*
//  - a pixel makes at most three result beats; req_tready drops while the queue lacks
//    room for three more beats on top of those of the pixel in flight, so a stalled
//    receiver backs up into the pixel side and nothing is lost
// reset
//  - clears position, run state, gap counts and the queue; config returns to
//    1024 x 1024 with one tile each way; the column memory needs no clearing since
//    the first row of a frame always overwrites it
module blank_gap_midpoint_finder (
   input  logic                            clock,
   input  logic                            reset,
   // pixel input
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,   // [0] ink, rest zero
   // result output
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [31:0]                     rsp_tdata,   // [10:0] position, [11] layout_ok,
                                                        // [21:12] column_gaps, [31:22] row_gaps
   output logic [1:0]                      rsp_tuser,   // [1:0] kind
   output logic                            rsp_tlast,
   // configuration writes
   input  logic                            csr_we,
   input  logic [bgmf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bgmf_pkg::SIZE_W-1:0]     csr_wdata
);
   import bgmf_pkg::*;

   // config registers
   logic [SIZE_W-1:0] frame_width_ff, frame_height_ff;
   logic [TILE_W-1:0] tiles_across_ff, tiles_down_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= SIZE_W'(MAX_WIDTH);
         frame_height_ff <= SIZE_W'(MAX_HEIGHT);
         tiles_across_ff <= TILE_W'(1);
         tiles_down_ff   <= TILE_W'(1);
      end else if (csr_we) begin
         case (csr_index)
            REG_FRAME_WIDTH:  frame_width_ff  <= csr_wdata;
            REG_FRAME_HEIGHT: frame_height_ff <= csr_wdata;
            REG_TILES_ACROSS: tiles_across_ff <= csr_wdata[TILE_W-1:0];
            REG_TILES_DOWN:   tiles_down_ff   <= csr_wdata[TILE_W-1:0];
            default: ;
         endcase
      end
   end

   logic [SIZE_W-1:0] width, height;
   assign width  = clamp_size(frame_width_ff, SIZE_W'(MAX_WIDTH));
   assign height = clamp_size(frame_height_ff, SIZE_W'(MAX_HEIGHT));

   // ------------------------------------------------------------------
   // accept stage: raster position and column memory read
   // ------------------------------------------------------------------
   logic          accept;
   logic [XW-1:0] x_pos_ff, x_pos_in;
   logic [YW-1:0] y_pos_ff, y_pos_in;
   logic          row_end, last_row;

   assign accept   = req_tvalid & req_tready;
   assign row_end  = SIZE_W'(x_pos_ff) >= (width - SIZE_W'(1));
   assign last_row = SIZE_W'(y_pos_ff) >= (height - SIZE_W'(1));

   always_comb begin
      x_pos_in = x_pos_ff;
      y_pos_in = y_pos_ff;
      if (accept) begin
         if (!row_end) begin
            x_pos_in = x_pos_ff + XW'(1);
         end else if (last_row) begin
            x_pos_in = '0;
            y_pos_in = '0;
         end else begin
            x_pos_in = '0;
            y_pos_in = y_pos_ff + YW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_pos_ff <= '0;
         y_pos_ff <= '0;
      end else begin
         x_pos_ff <= x_pos_in;
         y_pos_ff <= y_pos_in;
      end
   end

   // pixel stage registers
   logic          s1_valid_ff;
   logic          s1_ink_ff, s1_row_end_ff, s1_last_row_ff, s1_first_row_ff;
   logic [XW-1:0] s1_x_ff;
   logic [YW-1:0] s1_y_ff;
   logic          col_rd_ff;
   logic          byp_ff, byp_bit_ff;
   logic          col_bit;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         byp_ff      <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         if (accept) begin
            // same column written by the pixel stage on this edge: forward it
            byp_ff <= s1_valid_ff && (s1_x_ff == x_pos_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ink_ff       <= req_tdata[0];
         s1_row_end_ff   <= row_end;
         s1_last_row_ff  <= last_row;
         s1_first_row_ff <= (y_pos_ff == '0);
         s1_x_ff         <= x_pos_ff;
         s1_y_ff         <= y_pos_ff;
         byp_bit_ff      <= col_bit;
      end
   end

   // one ink bit per column, undefined until the first row writes it
   logic column_inked_mem [MAX_WIDTH];

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         column_inked_mem[s1_x_ff] <= col_bit;
      end
      if (accept) begin
         col_rd_ff <= column_inked_mem[x_pos_ff];
      end
   end

   // ------------------------------------------------------------------
   // pixel stage: run tracking and result generation
   // ------------------------------------------------------------------
   logic               row_inked_ff, row_inked_in;
   logic               col_open_ff, col_open_in;
   logic [XW-1:0]      col_start_ff, col_start_in;
   logic               row_open_ff, row_open_in;
   logic [YW-1:0]      row_start_ff, row_start_in;
   logic [COUNT_W-1:0] col_count_ff, col_count_in;
   logic [COUNT_W-1:0] row_count_ff, row_count_in;

   result_type         cand [RESULTS_MAX];
   logic [RESULTS_MAX-1:0] cand_vld;
   result_type         push_list [RESULTS_MAX];
   logic [NUM_W-1:0]   push_n;

   assign col_bit = s1_first_row_ff ? s1_ink_ff
                  : ((byp_ff ? byp_bit_ff : col_rd_ff) | s1_ink_ff);

   always_comb begin
      logic               c_blank, r_blank, ok;
      logic [POS_W-1:0]   sum;
      row_inked_in = row_inked_ff;
      col_open_in  = col_open_ff;
      col_start_in = col_start_ff;
      row_open_in  = row_open_ff;
      row_start_in = row_start_ff;
      col_count_in = col_count_ff;
      row_count_in = row_count_ff;
      cand_vld     = '0;
      c_blank      = ~col_bit;
      r_blank      = ~(row_inked_ff | s1_ink_ff);
      ok           = 1'b0;
      sum          = '0;
      for (int i = 0; i < RESULTS_MAX; i++) begin
         cand[i] = '0;
      end
      cand[0].kind = KIND_COLUMN_GAP;
      cand[1].kind = KIND_ROW_GAP;
      cand[2].kind = KIND_SUMMARY;

      if (s1_valid_ff) begin
         row_inked_in = row_inked_ff | s1_ink_ff;

         // columns settle while the last row streams
         if (s1_last_row_ff) begin
            if (col_open_ff && !c_blank) begin
               sum              = POS_W'(col_start_ff) + POS_W'(s1_x_ff);
               cand_vld[0]      = 1'b1;
               cand[0].position = sum >> 1;
               col_count_in     = bump(col_count_ff);
               col_open_in      = 1'b0;
            end else if (!col_open_ff && c_blank) begin
               col_open_in  = 1'b1;
               col_start_in = s1_x_ff;
            end
            // run still open at the right edge
            if (s1_row_end_ff && col_open_in) begin
               sum              = POS_W'(col_start_in) + width;
               cand_vld[0]      = 1'b1;
               cand[0].position = sum >> 1;
               col_count_in     = bump(col_count_in);
               col_open_in      = 1'b0;
            end
         end

         if (s1_row_end_ff) begin
            if (row_open_ff && !r_blank) begin
               sum              = POS_W'(row_start_ff) + POS_W'(s1_y_ff);
               cand_vld[1]      = 1'b1;
               cand[1].position = sum >> 1;
               row_count_in     = bump(row_count_ff);
               row_open_in      = 1'b0;
            end else if (!row_open_ff && r_blank) begin
               row_open_in  = 1'b1;
               row_start_in = s1_y_ff;
            end
            row_inked_in = 1'b0;

            if (s1_last_row_ff) begin
               // run still open at the bottom edge
               if (row_open_in) begin
                  sum              = POS_W'(row_start_in) + height;
                  cand_vld[1]      = 1'b1;
                  cand[1].position = sum >> 1;
                  row_count_in     = bump(row_count_in);
               end
               ok = ((SIZE_W'(col_count_in) + SIZE_W'(1)) == SIZE_W'(tiles_across_ff))
                 && ((SIZE_W'(row_count_in) + SIZE_W'(1)) == SIZE_W'(tiles_down_ff));
               cand_vld[2]         = 1'b1;
               cand[2].layout_ok   = ok;
               cand[2].column_gaps = col_count_in;
               cand[2].row_gaps    = row_count_in;
               // frame done: back to the start-of-frame state
               row_inked_in = 1'b0;
               col_open_in  = 1'b0;
               col_start_in = '0;
               row_open_in  = 1'b0;
               row_start_in = '0;
               col_count_in = '0;
               row_count_in = '0;
            end
         end
      end
   end

   // pack the valid results in order and flag the final one
   always_comb begin
      for (int i = 0; i < RESULTS_MAX; i++) begin
         push_list[i] = '0;
      end
      push_n = '0;
      for (int i = 0; i < RESULTS_MAX; i++) begin
         if (cand_vld[i]) begin
            push_list[push_n] = cand[i];
            push_n = push_n + NUM_W'(1);
         end
      end
      if (push_n != '0) begin
         push_list[push_n - NUM_W'(1)].last = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_inked_ff <= 1'b0;
         col_open_ff  <= 1'b0;
         col_start_ff <= '0;
         row_open_ff  <= 1'b0;
         row_start_ff <= '0;
         col_count_ff <= '0;
         row_count_ff <= '0;
      end else begin
         row_inked_ff <= row_inked_in;
         col_open_ff  <= col_open_in;
         col_start_ff <= col_start_in;
         row_open_ff  <= row_open_in;
         row_start_ff <= row_start_in;
         col_count_ff <= col_count_in;
         row_count_ff <= row_count_in;
      end
   end

   // ------------------------------------------------------------------
   // result queue
   // ------------------------------------------------------------------
   result_type         fifo_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CW-1:0] count_ff, count_in;
   logic [FIFO_AW-1:0] wr_idx [RESULTS_MAX];
   logic               pop;
   result_type         head;

   assign pop  = rsp_tvalid & rsp_tready;
   assign head = fifo_ff[rd_ptr_ff];

   // room for a full burst from the pixel in flight and the next one
   assign req_tready = ((FIFO_CW + 1)'(count_ff)
                        + (s1_valid_ff ? (FIFO_CW + 1)'(RESULTS_MAX) : '0))
                       <= (FIFO_CW + 1)'(FIFO_DEPTH - RESULTS_MAX);

   always_comb begin
      for (int j = 0; j < RESULTS_MAX; j++) begin
         wr_idx[j] = wr_ptr_ff + FIFO_AW'(j);
      end
      wr_ptr_in = wr_ptr_ff + FIFO_AW'(push_n);
      rd_ptr_in = rd_ptr_ff + FIFO_AW'(pop);
      count_in  = count_ff + FIFO_CW'(push_n) - FIFO_CW'(pop);
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < RESULTS_MAX; j++) begin
         if (NUM_W'(j) < push_n) begin
            fifo_ff[wr_idx[j]] <= push_list[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign rsp_tvalid = (count_ff != '0);
   assign rsp_tdata  = {head.row_gaps, head.column_gaps, head.layout_ok, head.position};
   assign rsp_tuser  = head.kind;
   assign rsp_tlast  = head.last;

endmodule

>>> tb/testbench.sv
// self-checking testbench for blank_gap_midpoint_finder: streams binarised frames through
// the pixel port and checks every result beat against an in-bench projection predictor
// depends on bgmf_pkg and the blank_gap_midpoint_finder rtl
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import bgmf_pkg::*;

   // ---------------------------------------------------------------- dut signals
   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [7:0]           req_tdata  = '0;   // [0] ink
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [31:0]          rsp_tdata;         // [10:0] position, [11] layout_ok,
                                            // [21:12] column_gaps, [31:22] row_gaps
   logic [1:0]           rsp_tuser;         // [1:0] kind
   logic                 rsp_tlast;
   logic                 csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index  = '0;
   logic [SIZE_W-1:0]    csr_wdata  = '0;

   blank_gap_midpoint_finder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // 8 ns period
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor state
   // own copy of the registers, reset values as in the block
   logic [SIZE_W-1:0]  width_reg  = SIZE_W'(1024);
   logic [SIZE_W-1:0]  height_reg = SIZE_W'(1024);
   logic [TILE_W-1:0]  across_reg = TILE_W'(1);
   logic [TILE_W-1:0]  down_reg   = TILE_W'(1);

   // projection profile and run tracking
   bit                 col_ink_mem [MAX_WIDTH];
   logic [XW-1:0]      x_at       = '0;
   logic [YW-1:0]      y_at       = '0;
   logic               row_ink    = 1'b0;
   logic               col_open   = 1'b0;
   logic [XW-1:0]      col_start  = '0;
   logic               row_open   = 1'b0;
   logic [YW-1:0]      row_start  = '0;
   logic [COUNT_W-1:0] col_gaps   = '0;
   logic [COUNT_W-1:0] row_gaps   = '0;
   bit                 frame_done = 1'b0;

   result_type         fresh_beats [$];   // beats caused by the pixel just accepted
   result_type         typed_beats [$];   // hand-written expectation for the next pixel
   result_type         gaps_due    [$];   // expected beats not yet seen on rsp

   int                 fail_count    = 0;
   int                 random_pixels = 0;
   bit                 calm          = 1'b0;
   bit                 quiet_send    = 1'b0;
   bit                 quiet_recv    = 1'b0;

   // append helpers for the beat queues
   function automatic void note_fresh(input result_type b);
      fresh_beats.insert(fresh_beats.size(), b);
   endfunction

   function automatic void note_typed(input result_type b);
      typed_beats.insert(typed_beats.size(), b);
   endfunction

   function automatic void note_due(input result_type b);
      gaps_due.insert(gaps_due.size(), b);
   endfunction

   function automatic result_type beat(input kind_type k, input int unsigned pos,
                                       input bit ok, input int unsigned cg,
                                       input int unsigned rg, input bit lst);
      result_type b;
      b.kind        = k;
      b.position    = POS_W'(pos);
      b.layout_ok   = ok;
      b.column_gaps = COUNT_W'(cg);
      b.row_gaps    = COUNT_W'(rg);
      b.last        = lst;
      return b;
   endfunction

   // zero behaves as one, anything past the maximum saturates
   function automatic int unsigned clamp_dim(input logic [SIZE_W-1:0] v, input int unsigned lim);
      int unsigned r;
      r = 32'(v);
      if (r == 0) r = 1;
      if (r > lim) r = lim;
      return r;
   endfunction

   function automatic logic [COUNT_W-1:0] count_up(input logic [COUNT_W-1:0] c);
      return (c == '1) ? c : c + COUNT_W'(1);
   endfunction

   // one pixel through the projection: updates the profile, pushes any gap midpoints
   // and the frame summary onto fresh_beats in column, row, summary order
   function automatic void find_gaps_for_pixel(input bit ink);
      int unsigned w;
      int unsigned h;
      int unsigned x;
      bit          row_end;
      bit          last_row;
      bit          col_bit;
      bit          ok;
      w        = clamp_dim(width_reg, MAX_WIDTH);
      h        = clamp_dim(height_reg, MAX_HEIGHT);
      x        = 32'(x_at);   // x_at is XW bits wide, so always inside the column store
      row_end  = (32'(x_at) >= w - 1);
      last_row = (32'(y_at) >= h - 1);

      // first row overwrites the column store, later rows accumulate into it
      col_bit           = (y_at == '0) ? ink : (col_ink_mem[x_at] | ink);
      col_ink_mem[x_at] = col_bit;
      row_ink           = row_ink | ink;

      // column runs are only final once the last row is streaming
      if (last_row) begin
         if (col_open && col_bit) begin
            note_fresh(beat(KIND_COLUMN_GAP, (32'(col_start) + x) / 2, 0, 0, 0, 0));
            col_gaps = count_up(col_gaps);
            col_open = 1'b0;
         end else if (!col_open && !col_bit) begin
            col_open  = 1'b1;
            col_start = x_at;
         end
         // a run reaching the right edge closes at the width
         if (row_end && col_open) begin
            note_fresh(beat(KIND_COLUMN_GAP, (32'(col_start) + w) / 2, 0, 0, 0, 0));
            col_gaps = count_up(col_gaps);
            col_open = 1'b0;
         end
      end

      if (row_end) begin
         if (row_open && row_ink) begin
            note_fresh(beat(KIND_ROW_GAP, (32'(row_start) + 32'(y_at)) / 2, 0, 0, 0, 0));
            row_gaps = count_up(row_gaps);
            row_open = 1'b0;
         end else if (!row_open && !row_ink) begin
            row_open  = 1'b1;
            row_start = y_at;
         end
         row_ink = 1'b0;
         if (last_row) begin
            // a run reaching the bottom edge closes at the height
            if (row_open) begin
               note_fresh(beat(KIND_ROW_GAP, (32'(row_start) + h) / 2, 0, 0, 0, 0));
               row_gaps = count_up(row_gaps);
               row_open = 1'b0;
            end
            ok = (int'(col_gaps) + 1 == int'(across_reg)) &&
                 (int'(row_gaps) + 1 == int'(down_reg));
            note_fresh(beat(KIND_SUMMARY, 0, ok, col_gaps, row_gaps, 0));
            // frame end: everything but the column store goes back to reset
            x_at      = '0;
            y_at      = '0;
            col_open  = 1'b0;
            col_start = '0;
            row_open  = 1'b0;
            row_start = '0;
            col_gaps  = '0;
            row_gaps  = '0;
            frame_done = 1'b1;
         end else begin
            x_at = '0;
            y_at = y_at + YW'(1);
         end
      end else begin
         x_at = x_at + XW'(1);
      end

      if (fresh_beats.size() != 0) fresh_beats[fresh_beats.size()-1].last = 1'b1;
   endfunction

   // ---------------------------------------------------------------- pixel driver
   // inputs move on the falling edge; acceptance is sampled on the rising edge
   task automatic send_pixel(input bit ink);
      int gap;
      if (!quiet_send && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 7);
         @(negedge clock) req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, ink};
      do @(posedge clock); while (!req_tready);
      find_gaps_for_pixel(ink);
      if (typed_beats.size() != 0) begin
         foreach (typed_beats[i]) note_due(typed_beats[i]);
         typed_beats.delete();
      end else begin
         foreach (fresh_beats[i]) note_due(fresh_beats[i]);
      end
      fresh_beats.delete();
   endtask

   // stop sending, wait for every expected beat, then let the pipeline run dry
   task automatic settle_block();
      @(negedge clock) req_tvalid <= 1'b0;
      while (gaps_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic cfg_write(input reg_index_type idx, input int unsigned val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= SIZE_W'(val);
      @(posedge clock);
      case (idx)
         REG_FRAME_WIDTH:  width_reg  = SIZE_W'(val);
         REG_FRAME_HEIGHT: height_reg = SIZE_W'(val);
         REG_TILES_ACROSS: across_reg = TILE_W'(val);
         REG_TILES_DOWN:   down_reg   = TILE_W'(val);
         default: ;
      endcase
      @(negedge clock) csr_we <= 1'b0;
   endtask

   task automatic pick_idling();
      quiet_send = calm || ($urandom_range(0, 3) == 0);
      quiet_recv = calm || ($urandom_range(0, 3) == 0);
   endtask

   task automatic stream_to_frame_end(input int pct);
      while (!frame_done) send_pixel($urandom_range(0, 99) < pct);
   endtask

   // a whole extreme frame, here a tall single column
   task automatic big_frame(input int unsigned wv, input int unsigned hv, input int pct);
      settle_block();
      pick_idling();
      frame_done = 1'b0;
      cfg_write(REG_FRAME_WIDTH, wv);
      cfg_write(REG_FRAME_HEIGHT, hv);
      cfg_write(REG_TILES_ACROSS, $urandom_range(0, 127));
      cfg_write(REG_TILES_DOWN, $urandom_range(0, 127));
      stream_to_frame_end(pct);
   endtask

   // small frame, usually with blank bands cut through it, tile counts usually set to match
   task automatic play_small_frame();
      int wr, hr, w, h, dens, cg, rg, r, c;
      int unsigned ta, td;
      bit noisy;
      bit img [0:15][0:15];
      bit col_cut [0:15];
      bit row_cut [0:15];
      bit col_blank [0:15];
      bit row_blank [0:15];
      wr    = $urandom_range(0, 12);
      hr    = $urandom_range(0, 8);
      w     = (wr == 0) ? 1 : wr;
      h     = (hr == 0) ? 1 : hr;
      noisy = ($urandom_range(0, 9) == 0);
      dens  = $urandom_range(10, 95);
      for (c = 0; c < 16; c++) col_cut[c] = ($urandom_range(0, 99) < 30);
      for (r = 0; r < 16; r++) row_cut[r] = ($urandom_range(0, 99) < 25);
      for (r = 0; r < h; r++) begin
         for (c = 0; c < w; c++) begin
            if (noisy) img[r][c] = 1'($urandom_range(0, 1));
            else img[r][c] = !col_cut[c] && !row_cut[r] && ($urandom_range(0, 99) < dens);
         end
      end
      // blank profile of what was actually drawn, then count the runs
      for (c = 0; c < w; c++) col_blank[c] = 1'b1;
      for (r = 0; r < h; r++) row_blank[r] = 1'b1;
      for (r = 0; r < h; r++) begin
         for (c = 0; c < w; c++) begin
            if (img[r][c]) begin
               col_blank[c] = 1'b0;
               row_blank[r] = 1'b0;
            end
         end
      end
      cg = 0;
      rg = 0;
      for (c = 0; c < w; c++) if (col_blank[c] && (c == 0 || !col_blank[c-1])) cg++;
      for (r = 0; r < h; r++) if (row_blank[r] && (r == 0 || !row_blank[r-1])) rg++;
      // high bits beyond the tile register are written too at times
      ta = ($urandom_range(0, 9) < 6) ? cg + 1 : $urandom_range(0, 2047);
      td = ($urandom_range(0, 9) < 6) ? rg + 1 : $urandom_range(0, 2047);

      settle_block();
      pick_idling();
      cfg_write(REG_FRAME_WIDTH, wr);
      cfg_write(REG_FRAME_HEIGHT, hr);
      cfg_write(REG_TILES_ACROSS, ta);
      cfg_write(REG_TILES_DOWN, td);
      for (r = 0; r < h; r++) begin
         for (c = 0; c < w; c++) begin
            send_pixel(img[r][c]);
            random_pixels++;
         end
      end
   endtask

   // ---------------------------------------------------------------- receiver
   // tready drops in random bursts unless this frame runs quiet
   int stall_left = 0;
   always @(negedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (!quiet_recv && $urandom_range(0, 6) == 0) begin
         stall_left <= $urandom_range(0, 6);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // ---------------------------------------------------------------- result checker
   always @(posedge clock) begin : check_beats
      result_type got;
      result_type want;
      bit         bad;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.kind        = kind_type'(rsp_tuser);
         got.position    = rsp_tdata[10:0];
         got.layout_ok   = rsp_tdata[11];
         got.column_gaps = rsp_tdata[21:12];
         got.row_gaps    = rsp_tdata[31:22];
         got.last        = rsp_tlast;
         if (gaps_due.size() == 0) begin
            if (fail_count < 10)
               $display("unexpected beat: kind %0d pos %0d ok %0d cg %0d rg %0d last %0d",
                        got.kind, got.position, got.layout_ok, got.column_gaps,
                        got.row_gaps, got.last);
            fail_count++;
         end else begin
            want = gaps_due.pop_front();
            bad  = (got.kind != want.kind) || (got.position != want.position) ||
                   (got.layout_ok != want.layout_ok) ||
                   (got.column_gaps != want.column_gaps) ||
                   (got.row_gaps != want.row_gaps) || (got.last != want.last);
            if (bad) begin
               if (fail_count < 10)
                  $display("mismatch: expected kind %0d pos %0d ok %0d cg %0d rg %0d last %0d, %s",
                           want.kind, want.position, want.layout_ok, want.column_gaps,
                           want.row_gaps, want.last,
                           $sformatf("got kind %0d pos %0d ok %0d cg %0d rg %0d last %0d",
                                     got.kind, got.position, got.layout_ok,
                                     got.column_gaps, got.row_gaps, got.last));
               fail_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------- directed table
   typedef struct {
      bit            is_cfg;
      reg_index_type idx;
      int unsigned   val;
      bit            ink;
      int            n_typed;    // zero: predictor decides
      result_type    typed [3];
   } plan_row_type;

   plan_row_type plan [$];

   function automatic void add_row(input plan_row_type p);
      plan.insert(plan.size(), p);
   endfunction

   function automatic plan_row_type blank_row();
      plan_row_type p;
      p.is_cfg   = 1'b0;
      p.idx      = REG_FRAME_WIDTH;
      p.val      = 0;
      p.ink      = 1'b0;
      p.n_typed  = 0;
      p.typed[0] = '0;
      p.typed[1] = '0;
      p.typed[2] = '0;
      return p;
   endfunction

   task automatic add_write(input reg_index_type idx, input int unsigned val);
      plan_row_type p;
      p        = blank_row();
      p.is_cfg = 1'b1;
      p.idx    = idx;
      p.val    = val;
      add_row(p);
   endtask

   task automatic add_pixel(input bit ink, input int n, input result_type a,
                            input result_type b, input result_type c);
      plan_row_type p;
      p          = blank_row();
      p.ink      = ink;
      p.n_typed  = n;
      p.typed[0] = a;
      p.typed[1] = b;
      p.typed[2] = c;
      add_row(p);
   endtask

   // ---------------------------------------------------------------- main sequence
   initial begin : stimulus
      int i;
      logic [11:0] bands;
      logic [4:0]  strip;
      repeat (8) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // 1x1 frames: width and height of zero act as one
      add_write(REG_FRAME_WIDTH, 0);
      add_write(REG_FRAME_HEIGHT, 0);
      // inked pixel after reset: no gaps, one tile each way matches
      add_pixel(1'b1, 1, beat(KIND_SUMMARY, 0, 1, 0, 0, 1), '0, '0);
      // white pixel: a column gap and a row gap both closed at the edge
      add_pixel(1'b0, 3, beat(KIND_COLUMN_GAP, 0, 0, 0, 0, 0),
                beat(KIND_ROW_GAP, 0, 0, 0, 0, 0), beat(KIND_SUMMARY, 0, 0, 1, 1, 1));
      // zero tiles can never match
      add_write(REG_TILES_ACROSS, 0);
      add_pixel(1'b1, 1, beat(KIND_SUMMARY, 0, 0, 0, 0, 1), '0, '0);
      add_write(REG_TILES_ACROSS, 2);
      add_write(REG_TILES_DOWN, 2);
      add_pixel(1'b0, 3, beat(KIND_COLUMN_GAP, 0, 0, 0, 0, 0),
                beat(KIND_ROW_GAP, 0, 0, 0, 0, 0), beat(KIND_SUMMARY, 0, 1, 1, 1, 1));
      // 4x3 frame, a blank column band and a blank middle row: 2x2 tiles
      add_write(REG_FRAME_WIDTH, 4);
      add_write(REG_FRAME_HEIGHT, 3);
      bands = 12'b1001_0000_1001;
      for (i = 11; i >= 0; i--) add_pixel(bands[i], 0, '0, '0, '0);
      // single-row frame: the first row is the last, two column gaps
      add_write(REG_FRAME_WIDTH, 5);
      add_write(REG_FRAME_HEIGHT, 1);
      add_write(REG_TILES_ACROSS, 3);
      add_write(REG_TILES_DOWN, 1);
      strip = 5'b01000;
      for (i = 4; i >= 0; i--) add_pixel(strip[i], 0, '0, '0, '0);

      foreach (plan[k]) begin
         if (plan[k].is_cfg) begin
            settle_block();
            cfg_write(plan[k].idx, plan[k].val);
         end else begin
            for (i = 0; i < plan[k].n_typed; i++) note_typed(plan[k].typed[i]);
            send_pixel(plan[k].ink);
         end
      end

      // size shrunk mid-frame: the current row ends at once since x is past the new
      // width, and the new height makes the following row the last one
      settle_block();
      pick_idling();
      frame_done = 1'b0;
      cfg_write(REG_FRAME_WIDTH, 6);
      cfg_write(REG_FRAME_HEIGHT, 6);
      cfg_write(REG_TILES_ACROSS, $urandom_range(1, 4));
      cfg_write(REG_TILES_DOWN, $urandom_range(1, 4));
      repeat (10) send_pixel(1'($urandom_range(0, 1)));
      settle_block();
      cfg_write(REG_FRAME_WIDTH, 3);
      cfg_write(REG_FRAME_HEIGHT, 3);
      stream_to_frame_end(50);

      // extremes: oversize width saturates to the maximum, then a narrower width cuts
      // the single row short; after that a tall one-pixel column
      settle_block();
      pick_idling();
      frame_done = 1'b0;
      cfg_write(REG_FRAME_WIDTH, 2047);
      cfg_write(REG_FRAME_HEIGHT, 1);
      cfg_write(REG_TILES_ACROSS, $urandom_range(0, 127));
      cfg_write(REG_TILES_DOWN, $urandom_range(0, 127));
      repeat (12) send_pixel($urandom_range(0, 99) < 15);
      settle_block();
      cfg_write(REG_FRAME_WIDTH, 8);
      stream_to_frame_end(15);
      big_frame(1, 24, 20);

      // random small frames, the tail end with no idling on either side
      while (random_pixels < 160) begin
         if (random_pixels >= 120) calm = 1'b1;
         play_small_frame();
      end

      // every expectation must drain, otherwise the time limit fires
      settle_block();
      repeat (10) @(posedge clock);
      if (fail_count == 0 && gaps_due.size() == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

   // time limit, far beyond the slowest legal run
   initial begin : time_limit
      #(5_000_000);
      $display("testbench failed");
      $finish;
   end

endmodule

>>> sim.f
rtl/bgmf_pkg.sv
rtl/blank_gap_midpoint_finder.sv
tb/testbench.sv
